### rtl/dvmh_pkg.sv
// ----------------------------------------------------------------------------
// dvmh_pkg
// Shared types and constants of the drive voltage monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package dvmh_pkg;

    localparam int ADC_BITS_DEFAULT = 10;

    localparam int TENTHS_W = 11;
    localparam int VOLTS_W  = 13;
    localparam int SPAN_W   = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [SPAN_W-1:0]   DRIVE_SPAN  = SPAN_W'(1900);
    localparam logic [SPAN_W-1:0]   XDCR_SPAN   = SPAN_W'(6490);
    localparam logic [VOLTS_W-1:0]  XDCR_OFFSET = VOLTS_W'(285);

    localparam logic [TENTHS_W-1:0] RELAY_ON_RST  = TENTHS_W'(500);
    localparam logic [TENTHS_W-1:0] RELAY_OFF_RST = TENTHS_W'(400);
    localparam logic [TENTHS_W-1:0] WARN_DRV_RST  = TENTHS_W'(1000);
    localparam logic [VOLTS_W-1:0]  WARN_XDCR_RST = VOLTS_W'(4000);
    localparam logic [TENTHS_W-1:0] TRIP_DRV_RST  = TENTHS_W'(1200);
    localparam logic [VOLTS_W-1:0]  TRIP_XDCR_RST = VOLTS_W'(4500);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RELAY_ON  = 3'd0,
        REG_RELAY_OFF = 3'd1,
        REG_WARN_DRV  = 3'd2,
        REG_WARN_XDCR = 3'd3,
        REG_TRIP_DRV  = 3'd4,
        REG_TRIP_XDCR = 3'd5
    } cfg_reg_t;

endpackage

`default_nettype wire

### rtl/drive_voltage_monitor_hysteresis.sv
// An input transaction reaches result valid through the input register, the
// product register and the result register.
// Throughput: one transaction per cycle while m_tready is high; the three stages advance
// on their own ready, so a stalled result does not block an empty stage behind it.
// Reset: rst_n clears stage valids, relay, warning, fault and loads the
// threshold registers with their defaults.
// ----------------------------------------------------------------------------
// drive_voltage_monitor_hysteresis
// Scales drive and transducer converter samples, drives a hysteresis relay,
// raises a warning and latches an overload fault.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_voltage_monitor_hysteresis
    import dvmh_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEFAULT,
    localparam int IN_W = ((2 * ADC_BITS + 7) / 8) * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,   // drive_sample, transducer_sample, zero pad
    input  wire logic                  s_tuser,   // clear_fault

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // drive_tenths, transducer_volts
    output logic [2:0]                 m_tuser,   // relay_on, warning, fault

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [VOLTS_W-1:0]    cfg_data
);

    localparam int PROD_W = ADC_BITS + SPAN_W;
    localparam logic [PROD_W-1:0] FS_MASK = PROD_W'((1 << ADC_BITS) - 1);

    function automatic logic [PROD_W-1:0] div_fs(input logic [PROD_W-1:0] x);
        logic [PROD_W-1:0] q0;
        logic [PROD_W-1:0] r0;
        logic [PROD_W-1:0] q1;
        logic [PROD_W-1:0] r1;
        q0 = x >> ADC_BITS;
        r0 = (x & FS_MASK) + q0;
        q1 = r0 >> ADC_BITS;
        r1 = (r0 & FS_MASK) + q1;
        return q0 + q1 + ((r1 >= FS_MASK) ? PROD_W'(1) : PROD_W'(0));
    endfunction

    // threshold registers
    logic [TENTHS_W-1:0] relay_on_reg;
    logic [TENTHS_W-1:0] relay_off_reg;
    logic [TENTHS_W-1:0] warn_drv_reg;
    logic [VOLTS_W-1:0]  warn_xdcr_reg;
    logic [TENTHS_W-1:0] trip_drv_reg;
    logic [VOLTS_W-1:0]  trip_xdcr_reg;

    // pipeline control
    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;

    // stage payloads
    logic [ADC_BITS-1:0] dcode_reg;
    logic [ADC_BITS-1:0] tcode_reg;
    logic                clr1_reg;
    logic [PROD_W-1:0]   dprod_reg;
    logic [PROD_W-1:0]   tprod_reg;
    logic                clr2_reg;
    logic [PROD_W-1:0]   dprod_next;
    logic [PROD_W-1:0]   tprod_next;

    // state
    logic relay_reg, warn_reg, fault_reg;
    logic relay_next, warn_next, fault_next;
    logic [TENTHS_W-1:0] drive_next;
    logic [VOLTS_W-1:0]  xdcr_next;
    logic [PROD_W-1:0]   dq;
    logic [PROD_W-1:0]   tq;
    logic                fault_cleared;

    // result register
    logic [TENTHS_W-1:0] drive_reg;
    logic [VOLTS_W-1:0]  xdcr_reg;
    logic                relay_out_reg, warn_out_reg, fault_out_reg;

    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_on_reg  <= RELAY_ON_RST;
            relay_off_reg <= RELAY_OFF_RST;
            warn_drv_reg  <= WARN_DRV_RST;
            warn_xdcr_reg <= WARN_XDCR_RST;
            trip_drv_reg  <= TRIP_DRV_RST;
            trip_xdcr_reg <= TRIP_XDCR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RELAY_ON:  relay_on_reg  <= cfg_data[TENTHS_W-1:0];
                REG_RELAY_OFF: relay_off_reg <= cfg_data[TENTHS_W-1:0];
                REG_WARN_DRV:  warn_drv_reg  <= cfg_data[TENTHS_W-1:0];
                REG_WARN_XDCR: warn_xdcr_reg <= cfg_data;
                REG_TRIP_DRV:  trip_drv_reg  <= cfg_data[TENTHS_W-1:0];
                REG_TRIP_XDCR: trip_xdcr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            relay_reg <= 1'b0;
            warn_reg  <= 1'b0;
            fault_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= s_tvalid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
            if (ready3 && v2_reg)
            begin
                relay_reg <= relay_next;
                warn_reg  <= warn_next;
                fault_reg <= fault_next;
            end
        end
    end

    assign dprod_next = PROD_W'(dcode_reg) * PROD_W'(DRIVE_SPAN);
    assign tprod_next = PROD_W'(tcode_reg) * PROD_W'(XDCR_SPAN);

    always_comb
    begin
        dq            = div_fs(dprod_reg);
        tq            = div_fs(tprod_reg);
        drive_next    = dq[TENTHS_W-1:0];
        xdcr_next     = tq[VOLTS_W-1:0] + XDCR_OFFSET;
        fault_cleared = fault_reg && !clr2_reg;
        relay_next    = relay_reg;
        warn_next     = warn_reg;
        fault_next    = fault_cleared;
        if (!fault_cleared)
        begin
            if (relay_reg)
                relay_next = !(drive_next < relay_off_reg);
            else
                relay_next = drive_next > relay_on_reg;
            warn_next  = (drive_next > warn_drv_reg) || (xdcr_next > warn_xdcr_reg);
            fault_next = (drive_next > trip_drv_reg) || (xdcr_next > trip_xdcr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && s_tvalid)
        begin
            dcode_reg <= s_tdata[ADC_BITS-1:0];
            tcode_reg <= s_tdata[2*ADC_BITS-1:ADC_BITS];
            clr1_reg  <= s_tuser;
        end
        if (ready2 && v1_reg)
        begin
            dprod_reg <= dprod_next;
            tprod_reg <= tprod_next;
            clr2_reg  <= clr1_reg;
        end
        if (ready3 && v2_reg)
        begin
            drive_reg     <= drive_next;
            xdcr_reg      <= xdcr_next;
            relay_out_reg <= relay_next;
            warn_out_reg  <= warn_next;
            fault_out_reg <= fault_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {xdcr_reg, drive_reg};
    assign m_tuser  = {fault_out_reg, warn_out_reg, relay_out_reg};

endmodule

`default_nettype wire

### rtl/dvmh_checker.sv
// ----------------------------------------------------------------------------
// dvmh_checker
// Port-level checks of the drive voltage monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dvmh_checker
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [23:0]           m_tdata,
    input  wire logic [2:0]            m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_xdcr_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:11] >= 13'd285)
        else $error("transducer volts below offset");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[10:0] <= 11'd1900)
        else $error("drive tenths above span");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind drive_voltage_monitor_hysteresis dvmh_checker u_dvmh_checker (.*);

`default_nettype wire
